>>> design/lcfm_pkg.sv
// ----------------------------------------------------------------------------
// lcfm_pkg
// Shared constants, codes and controller/datapath interface types for the
// lane centre finder.
// ----------------------------------------------------------------------------
package lcfm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_W      = 11;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // register index, taken from paddr[REG_SEL_BIT]
  localparam logic REG_WIDTH_IDX  = 1'b0;
  localparam logic REG_HEIGHT_IDX = 1'b1;

  localparam int COORD_W = 10;
  localparam int HITS_W  = 11;

  typedef enum logic [1:0] {
    OP_LX = 2'd0,
    OP_RX = 2'd1,
    OP_LY = 2'd2,
    OP_RY = 2'd3
  } op_t;

  typedef struct packed {
    logic pix_en;
    logic div_start;
    logic q_store;
    logic out_load;
    op_t  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic counts_nonzero;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/lcfm_div.sv
// ----------------------------------------------------------------------------
// lcfm_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module lcfm_div #(
  parameter int DIVIDEND_W = 21,
  parameter int DIVISOR_W  = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNTW = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] dq;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [CNTW-1:0]       cnt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;

  always_comb begin
    trial    = {rem, dq[DIVIDEND_W-1]};
    fits     = trial >= {1'b0, dsr};
    diff     = trial - {1'b0, dsr};
    rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dq  <= {dq[DIVIDEND_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = dq;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
`endif

endmodule

>>> design/lcfm_ctrl.sv
// ----------------------------------------------------------------------------
// lcfm_ctrl
// Controller: runs the pixel scan, sequences the four frame-end divisions
// (none when a side has no hits) and hands the result to the output register.
// ----------------------------------------------------------------------------
module lcfm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  lcfm_pkg::dp_status_t   status,
  output lcfm_pkg::ctrl_cmd_t    cmd
);
  import lcfm_pkg::*;

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_START = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      ST_RUN: begin
        cmd.pix_en = 1'b1;
        if (status.frame_end) begin
          op_next    = OP_LX;
          state_next = status.counts_nonzero ? ST_START : ST_EMIT;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.div_done) begin
          cmd.q_store = 1'b1;
          unique case (op)
            OP_LX: begin op_next = OP_RX; state_next = ST_START; end
            OP_RX: begin op_next = OP_LY; state_next = ST_START; end
            OP_LY: begin op_next = OP_RY; state_next = ST_START; end
            OP_RY: state_next = ST_EMIT;
            default: state_next = ST_EMIT;
          endcase
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      op    <= OP_LX;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("division started while divider busy");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == ST_WAIT)
    else $error("divider finished outside wait state");
`endif

endmodule

>>> design/lcfm_dp.sv
// ----------------------------------------------------------------------------
// lcfm_dp
// Datapath: raster counters, per-row hit search, frame accumulators,
// frame-end snapshot, divider, midpoint and output register.
// ----------------------------------------------------------------------------
module lcfm_dp #(
  parameter int MAX_WIDTH  = lcfm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lcfm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lcfm_pkg::CFG_W-1:0]    frame_width,
  input  logic [lcfm_pkg::CFG_W-1:0]    frame_height,
  input  logic                          pixel_valid,
  input  logic                          pixel_on,
  input  logic                          result_ready,
  input  lcfm_pkg::ctrl_cmd_t           cmd,
  output lcfm_pkg::dp_status_t          status,
  output logic                          result_valid,
  output logic [lcfm_pkg::COORD_W-1:0]  center_x,
  output logic [lcfm_pkg::COORD_W-1:0]  center_y,
  output logic [lcfm_pkg::HITS_W-1:0]   left_hits,
  output logic [lcfm_pkg::HITS_W-1:0]   right_hits,
  output logic                          center_valid
);
  import lcfm_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW  = CW + 1;
  localparam int RCMPW = RW + 1;
  localparam int SXW   = CW + HW;
  localparam int SYW   = RW + HW;
  localparam int DVW   = (SXW > SYW) ? SXW : SYW;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [WW-1:0]  centre;

  logic [CW-1:0]  col, col_next;
  logic [RW-1:0]  row, row_next;
  logic [CW-1:0]  left_col, left_col_next;
  logic           left_seen, left_seen_next;
  logic           right_seen, right_seen_next;
  logic [SXW-1:0] lsx, lsx_next, rsx, rsx_next;
  logic [SYW-1:0] lsy, lsy_next, rsy, rsy_next;
  logic [HW-1:0]  lc, lc_next, rc, rc_next;

  logic           accept;
  logic           hit_right, hit_left, row_end, last_row, frame_end;
  logic [CW-1:0]  lcol_cur;
  logic           lseen_cur;

  logic [SXW-1:0] s_lsx, s_rsx;
  logic [SYW-1:0] s_lsy, s_rsy;
  logic [HW-1:0]  s_lc, s_rc;
  logic           s_valid;

  logic [DVW-1:0] div_dividend, div_quotient;
  logic [HW-1:0]  div_divisor;
  logic           div_busy, div_done;

  logic [CW-1:0]  lx, rx;
  logic [RW-1:0]  ly, ry;
  logic [CW:0]    sum_x;
  logic [RW:0]    sum_y;

  always_comb begin
    if (frame_width < CFG_W'(2)) begin
      w_eff = WW'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height < CFG_W'(1)) begin
      h_eff = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
    centre = w_eff >> 1;
  end

  assign accept = pixel_valid & cmd.pix_en;

  always_comb begin
    hit_right = pixel_on && (CMPW'(col) >= CMPW'(centre)) && !right_seen;
    hit_left  = pixel_on && (CMPW'(col) <= CMPW'(centre));
    row_end   = !((CMPW'(col) + CMPW'(1)) < CMPW'(w_eff));
    last_row  = !((RCMPW'(row) + RCMPW'(1)) < RCMPW'(h_eff));
    frame_end = accept && row_end && last_row;
    lcol_cur  = hit_left ? col : left_col;
    lseen_cur = left_seen | hit_left;

    col_next        = col;
    row_next        = row;
    left_col_next   = left_col;
    left_seen_next  = left_seen;
    right_seen_next = right_seen;
    lsx_next        = lsx;
    lsy_next        = lsy;
    lc_next         = lc;
    rsx_next        = rsx;
    rsy_next        = rsy;
    rc_next         = rc;

    if (accept) begin
      if (hit_right) begin
        right_seen_next = 1'b1;
        rsx_next        = rsx + SXW'(col);
        rsy_next        = rsy + SYW'(row);
        rc_next         = rc + HW'(1);
      end
      left_col_next  = lcol_cur;
      left_seen_next = lseen_cur;
      if (row_end) begin
        if (lseen_cur) begin
          lsx_next = lsx + SXW'(lcol_cur);
          lsy_next = lsy + SYW'(row);
          lc_next  = lc + HW'(1);
        end
        left_seen_next  = 1'b0;
        right_seen_next = 1'b0;
        left_col_next   = '0;
        col_next        = '0;
        row_next        = last_row ? '0 : row + RW'(1);
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      left_col   <= '0;
      left_seen  <= 1'b0;
      right_seen <= 1'b0;
      lsx        <= '0;
      lsy        <= '0;
      lc         <= '0;
      rsx        <= '0;
      rsy        <= '0;
      rc         <= '0;
    end else begin
      col        <= col_next;
      row        <= row_next;
      left_col   <= left_col_next;
      left_seen  <= left_seen_next;
      right_seen <= right_seen_next;
      if (frame_end) begin
        lsx <= '0;
        lsy <= '0;
        lc  <= '0;
        rsx <= '0;
        rsy <= '0;
        rc  <= '0;
      end else begin
        lsx <= lsx_next;
        lsy <= lsy_next;
        lc  <= lc_next;
        rsx <= rsx_next;
        rsy <= rsy_next;
        rc  <= rc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      s_lsx   <= lsx_next;
      s_lsy   <= lsy_next;
      s_lc    <= lc_next;
      s_rsx   <= rsx_next;
      s_rsy   <= rsy_next;
      s_rc    <= rc_next;
      s_valid <= (lc_next != '0) && (rc_next != '0);
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_LX: begin div_dividend = DVW'(s_lsx); div_divisor = s_lc; end
      OP_RX: begin div_dividend = DVW'(s_rsx); div_divisor = s_rc; end
      OP_LY: begin div_dividend = DVW'(s_lsy); div_divisor = s_lc; end
      OP_RY: begin div_dividend = DVW'(s_rsy); div_divisor = s_rc; end
      default: begin div_dividend = DVW'(s_lsx); div_divisor = s_lc; end
    endcase
  end

  lcfm_div #(
    .DIVIDEND_W (DVW),
    .DIVISOR_W  (HW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.q_store) begin
      unique case (cmd.op)
        OP_LX: lx <= div_quotient[CW-1:0];
        OP_RX: rx <= div_quotient[CW-1:0];
        OP_LY: ly <= div_quotient[RW-1:0];
        OP_RY: ry <= div_quotient[RW-1:0];
        default: lx <= div_quotient[CW-1:0];
      endcase
    end
  end

  assign sum_x = {1'b0, lx} + {1'b0, rx};
  assign sum_y = {1'b0, ly} + {1'b0, ry};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      center_x     <= s_valid ? COORD_W'(sum_x >> 1) : '0;
      center_y     <= s_valid ? COORD_W'(sum_y >> 1) : '0;
      left_hits    <= HITS_W'(s_lc);
      right_hits   <= HITS_W'(s_rc);
      center_valid <= s_valid;
    end
  end

  always_comb begin
    status.frame_end      = frame_end;
    status.counts_nonzero = (lc_next != '0) && (rc_next != '0);
    status.div_busy       = div_busy;
    status.div_done       = div_done;
    status.out_free       = !result_valid || result_ready;
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || result_ready))
    else $error("result register overwritten");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !center_valid) |-> (center_x == '0 && center_y == '0))
    else $error("invalid result with nonzero centre");
`endif

endmodule

>>> design/lane_center_from_mask.sv
// ----------------------------------------------------------------------------
// lane_center_from_mask
// Lane centre finder on a binary mask streamed one pixel per transaction.
// ----------------------------------------------------------------------------
// Pixel channel (pixel_valid/pixel_ready/pixel_on) takes the mask in raster
// order, one pixel per cycle while scanning. Per row the nearest set pixel at
// or right of the centre column and at or left of it are found and summed.
// After the last pixel of the frame one result transaction leaves on the
// result channel: mean-point midpoint, hit counts and a valid flag.
// Frame end: four sequential divisions in one shared bit-serial divider whose
// dividend is the accumulator width (21 bits at default sizes); then the
// result is offered. With a side lacking hits the divisions are skipped and
// the result is offered directly. pixel_ready is low from frame end until
// the result is loaded and otherwise high, one pixel per cycle.
// A waiting result does not stop the next frame's pixels; only a new frame
// end holds off until the receiver has taken the previous result.
// APB port: frame_width at 0x0, frame_height at 0x4, write only while idle.
// Synchronous reset restores 640x480 and clears all counters.
// ----------------------------------------------------------------------------
module lane_center_from_mask #(
  parameter int MAX_WIDTH  = lcfm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lcfm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcfm_pkg::APB_AW-1:0]   paddr,
  input  logic [lcfm_pkg::APB_DW-1:0]   pwdata,
  output logic [lcfm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic                          pixel_on,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [lcfm_pkg::COORD_W-1:0]  center_x,
  output logic [lcfm_pkg::COORD_W-1:0]  center_y,
  output logic [lcfm_pkg::HITS_W-1:0]   left_hits,
  output logic [lcfm_pkg::HITS_W-1:0]   right_hits,
  output logic                          center_valid
);
  import lcfm_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  ctrl_cmd_t        cmd;
  dp_status_t       status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[REG_SEL_BIT] == REG_HEIGHT_IDX) begin
        frame_height <= pwdata[CFG_W-1:0];
      end else begin
        frame_width <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[REG_SEL_BIT] == REG_WIDTH_IDX) begin
      prdata = APB_DW'(frame_width);
    end else begin
      prdata = APB_DW'(frame_height);
    end
  end

  assign pixel_ready = cmd.pix_en;

  lcfm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  lcfm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pixel_valid  (pixel_valid),
    .pixel_on     (pixel_on),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .center_x     (center_x),
    .center_y     (center_y),
    .left_hits    (left_hits),
    .right_hits   (right_hits),
    .center_valid (center_valid)
  );

endmodule
